FILE: hw/rtl/linear_key_value_table_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the linear key-value table
// Concurrent checks clocked on i_clk and held off while i_rst_n is low.
// Define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef LINEAR_KEY_VALUE_TABLE_TOP_DEFINES_SVH
`define LINEAR_KEY_VALUE_TABLE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define LKVT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define LKVT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LKVT_ASSERT_IMP(lbl, ante, cons, msg)
`define LKVT_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/lkvt_pkg.sv
// ----------------------------------------------------------------------------
// lkvt_pkg
// Sizes, codes and controller/datapath interface types of the key-value table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lkvt_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;

    localparam int KEY_W    = 32;
    localparam int PAY_W    = 32;
    localparam int OUT_VAL_W = 32;
    localparam int USED_W   = 5;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // payload bits that survive storage
    localparam int VAL_KEEP = (VALUE_WIDTH < PAY_W) ? VALUE_WIDTH : PAY_W;

    localparam int S_DATA_W = KEY_W + PAY_W;
    localparam int M_FLD_W  = KEY_W + OUT_VAL_W + USED_W;
    localparam int M_DATA_W = ((M_FLD_W + 7) / 8) * 8;
    localparam int M_PAD_W  = M_DATA_W - M_FLD_W;

    typedef logic [CNT_W-1:0]       t_cnt;
    typedef logic [IDX_W-1:0]       t_idx;
    typedef logic [VALUE_WIDTH-1:0] t_val;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_FIND   = 2'd1,
        OP_ERASE  = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_NEW     = 3'd0,
        ST_UPDATED = 3'd1,
        ST_FOUND   = 3'd2,
        ST_MISS    = 3'd3,
        ST_ERASED  = 3'd4,
        ST_FULL    = 3'd5,
        ST_CLEARED = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture request, restart the walk
        logic issue;       // read next entry, advance walk index
        logic latch_hit;   // remember matching entry
        logic shift_start; // restart walk just above the hit
        logic shift;       // write read data one place down
        logic emit;        // commit update, load output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        t_op  op;
        logic scan_hit;
        logic drained;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: hw/rtl/lkvt_ctrl.sv
// ----------------------------------------------------------------------------
// lkvt_ctrl
// Sequencer for one table operation: search, optional erase shift, commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkvt_ctrl
    import lkvt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_op      i_op,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_op == OP_CLEAR) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_stat.scan_hit) begin
                    o_cmd.latch_hit = 1'b1;
                    if (i_stat.op == OP_ERASE) begin
                        o_cmd.shift_start = 1'b1;
                        n_state           = S_SHIFT;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (i_stat.drained) begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                o_cmd.issue = 1'b1;
                o_cmd.shift = 1'b1;
                if (i_stat.drained) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/lkvt_dp.sv
// ----------------------------------------------------------------------------
// lkvt_dp
// Entry memories, walk index, match compare, entry count and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkvt_dp
    import lkvt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  t_op                   i_op,
    input  logic signed [KEY_W-1:0] i_key,
    input  logic [PAY_W-1:0]      i_payload,
    output t_dp_stat              o_stat,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output t_status               o_status,
    output logic signed [KEY_W-1:0] o_key,
    output logic [OUT_VAL_W-1:0]  o_value,
    output logic [USED_W-1:0]     o_used
);

    logic [KEY_W-1:0] r_key_mem [CAPACITY];
    t_val             r_val_mem [CAPACITY];

    // control state
    t_cnt r_count;
    t_cnt r_idx;
    logic r_rdv;
    logic r_found;
    logic r_ovalid;

    // request and data registers
    t_op              r_op;
    logic [KEY_W-1:0] r_key;
    t_val             r_pay;
    t_idx             r_rdi;
    logic [KEY_W-1:0] r_rd_key;
    t_val             r_rd_val;
    t_idx             r_pos;
    t_val             r_fval;
    t_status          r_ostatus;
    logic [KEY_W-1:0] r_okey;
    logic [OUT_VAL_W-1:0] r_oval;
    logic [USED_W-1:0]    r_oused;

    logic             can_issue;
    logic             full;
    t_idx             rd_addr;
    logic             wr_key_en;
    logic             wr_val_en;
    t_idx             wr_addr;
    logic [KEY_W-1:0] wr_key;
    t_val             wr_val;
    t_status          res_status;
    logic [OUT_VAL_W-1:0] res_val;
    t_cnt             res_count;
    logic [OUT_VAL_W-1:0] pay_out;
    logic [OUT_VAL_W-1:0] fval_out;

    assign can_issue = (r_idx < r_count);
    assign full      = (r_count == t_cnt'(CAPACITY));
    assign rd_addr   = r_idx[IDX_W-1:0];
    assign pay_out   = OUT_VAL_W'(r_pay[VAL_KEEP-1:0]);
    assign fval_out  = OUT_VAL_W'(r_fval[VAL_KEEP-1:0]);

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue && can_issue) begin
            r_rd_key <= r_key_mem[rd_addr];
            r_rd_val <= r_val_mem[rd_addr];
        end
    end

    // single write port: erase shift or commit
    always_comb begin
        wr_key_en = 1'b0;
        wr_val_en = 1'b0;
        wr_addr   = r_pos;
        wr_key    = r_key;
        wr_val    = r_pay;
        if (i_cmd.shift && r_rdv) begin
            wr_key_en = 1'b1;
            wr_val_en = 1'b1;
            wr_addr   = r_rdi - t_idx'(1);
            wr_key    = r_rd_key;
            wr_val    = r_rd_val;
        end else if (i_cmd.emit && (r_op == OP_INSERT)) begin
            if (r_found) begin
                wr_val_en = 1'b1;
            end else if (!full) begin
                wr_key_en = 1'b1;
                wr_val_en = 1'b1;
                wr_addr   = r_count[IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_key_en) begin
            r_key_mem[wr_addr] <= wr_key;
        end
        if (wr_val_en) begin
            r_val_mem[wr_addr] <= wr_val;
        end
    end

    // outcome of the finished operation
    always_comb begin
        res_status = ST_MISS;
        res_val    = '0;
        res_count  = r_count;
        case (r_op)
            OP_INSERT: begin
                if (r_found) begin
                    res_status = ST_UPDATED;
                    res_val    = pay_out;
                end else if (!full) begin
                    res_status = ST_NEW;
                    res_val    = pay_out;
                    res_count  = r_count + t_cnt'(1);
                end else begin
                    res_status = ST_FULL;
                end
            end
            OP_FIND: begin
                if (r_found) begin
                    res_status = ST_FOUND;
                    res_val    = fval_out;
                end
            end
            OP_ERASE: begin
                if (r_found) begin
                    res_status = ST_ERASED;
                    res_count  = r_count - t_cnt'(1);
                end
            end
            OP_CLEAR: begin
                res_status = ST_CLEARED;
                res_count  = '0;
            end
            default: begin
                res_status = ST_MISS;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_idx    <= '0;
            r_rdv    <= 1'b0;
            r_found  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx   <= '0;
                r_rdv   <= 1'b0;
                r_found <= 1'b0;
            end else if (i_cmd.shift_start) begin
                r_idx <= t_cnt'(r_rdi) + t_cnt'(1);
                r_rdv <= 1'b0;
            end else if (i_cmd.issue) begin
                r_rdv <= can_issue;
                if (can_issue) begin
                    r_idx <= r_idx + t_cnt'(1);
                end
            end
            if (i_cmd.latch_hit) begin
                r_found <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_count  <= res_count;
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_key <= i_key;
            r_pay <= t_val'(i_payload[VAL_KEEP-1:0]);
        end
        if (i_cmd.issue && can_issue && !i_cmd.shift_start) begin
            r_rdi <= rd_addr;
        end
        if (i_cmd.latch_hit) begin
            r_pos  <= r_rdi;
            r_fval <= r_rd_val;
        end
        if (i_cmd.emit) begin
            r_ostatus <= res_status;
            r_okey    <= r_key;
            r_oval    <= res_val;
            r_oused   <= USED_W'(res_count);
        end
    end

    assign o_stat.op       = r_op;
    assign o_stat.scan_hit = r_rdv && (r_rd_key == r_key);
    assign o_stat.drained  = !r_rdv && !can_issue;
    assign o_stat.out_free = !r_ovalid || i_out_ready;

    assign o_out_valid = r_ovalid;
    assign o_status    = r_ostatus;
    assign o_key       = r_okey;
    assign o_value     = r_oval;
    assign o_used      = r_oused;

endmodule

FILE: hw/rtl/linear_key_value_table_top.sv
// ----------------------------------------------------------------------------
// linear_key_value_table_top
// A small key-value table of up to CAPACITY entries kept in insertion order.
// Each input transfer carries an operation (insert, find, erase, clear), a
// 32-bit key and a payload word, and yields exactly one result transfer with
// a status, the echoed key, a value and the entry count after the operation.
// The table is searched from entry 0 upward through one read port of the
// entry memory, one entry per cycle; an erase then walks the later entries
// through the same port and moves each one place down. One operation is in
// work at a time. An insert of a new key into a full table is refused with
// the full status. The result sits in an output register, so the next
// operation is taken while a result still waits; the commit waits only if
// that register is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "linear_key_value_table_top_defines.svh"

module linear_key_value_table_top
    import lkvt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // slave side
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,   // [31:0] key, [63:32] payload
    input  logic [OP_W-1:0]     i_s_tuser,   // [1:0] cmd
    // master side
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,   // [31:0] key_out, [63:32] value_out,
                                             // [68:64] entries_used, rest zero
    output logic [STATUS_W-1:0] o_m_tuser    // [2:0] status
);

    t_dp_cmd dp_cmd;
    t_dp_stat dp_stat;
    t_op     in_op;
    t_status out_status;
    logic signed [KEY_W-1:0] out_key;
    logic [OUT_VAL_W-1:0]    out_val;
    logic [USED_W-1:0]       out_used;

    assign in_op = t_op'(i_s_tuser);

    // sequencer: accept, search, shift, commit
    lkvt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_op    (in_op),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // entry memories, count and the result register
    lkvt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_op        (in_op),
        .i_key       (i_s_tdata[KEY_W-1:0]),
        .i_payload   (i_s_tdata[KEY_W +: PAY_W]),
        .o_stat      (dp_stat),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_status    (out_status),
        .o_key       (out_key),
        .o_value     (out_val),
        .o_used      (out_used)
    );

    // pack the result fields from the lowest bit up
    assign o_m_tdata = {{M_PAD_W{1'b0}}, out_used, out_val, out_key};
    assign o_m_tuser = out_status;

    // one operation at a time: an accepted transfer closes the input
    `LKVT_ASSERT_NXT(a_single_op, i_s_tvalid && o_s_tready, !o_s_tready, "input open while busy")
    // a commit never overwrites a result that has not been taken
    `LKVT_ASSERT_IMP(a_emit_free, dp_cmd.emit, !o_m_tvalid || i_m_tready, "result overwritten")
    // a clear leaves the table empty
    `LKVT_ASSERT_IMP(a_clear_empty, o_m_tvalid && (o_m_tuser == ST_CLEARED), ~|out_used, "entries left")
    // codes above found (miss, erased, full, cleared) carry a zero value
    `LKVT_ASSERT_IMP(a_zero_value, o_m_tvalid && (o_m_tuser > ST_FOUND), ~|out_val, "stray value")

endmodule

FILE: sim/kv_table_checker.sv
// ----------------------------------------------------------------------------
// kv_table_checker
// Watches both stream channels of the key-value table. It keeps its own copy
// of the table and predicts one result per accepted operation. Each accepted
// result is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kv_table_checker
    import lkvt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,   // [31:0] key, [63:32] payload
    input  logic [OP_W-1:0]     i_s_tuser,   // [1:0] cmd
    input  logic                i_m_tvalid,
    input  logic                i_m_tready,
    input  logic [M_DATA_W-1:0] i_m_tdata,   // [31:0] key_out, [63:32] value_out,
                                             // [68:64] entries_used, rest zero
    input  logic [STATUS_W-1:0] i_m_tuser,   // [2:0] status
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_checked,
    output int                  o_peak_used,
    output logic [6:0]          o_status_seen
);

    localparam int MAX_PRINTED = 100;

    typedef struct {
        t_status              status;
        logic [KEY_W-1:0]     key;
        logic [OUT_VAL_W-1:0] value;
        logic [USED_W-1:0]    used;
    } t_table_result;

    logic [KEY_W-1:0] table_keys [CAPACITY];
    t_val             table_vals [CAPACITY];
    int               table_count = 0;
    t_table_result    predicted_results [$];

    initial begin
        o_fail_count  = 0;
        o_pending     = 0;
        o_checked     = 0;
        o_peak_used   = 0;
        o_status_seen = '0;
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        o_fail_count++;
        if (o_fail_count <= MAX_PRINTED)
            $display("[%0t] result %0d: %s got 0x%08h, want 0x%08h",
                     $time, o_checked, field, got, want);
    endtask

    // Apply one operation to the local table copy and return its result.
    task automatic apply_table_op(input t_op op, input logic [KEY_W-1:0] key,
                                  input logic [PAY_W-1:0] pay,
                                  output t_table_result res);
        int   hit;
        int   i;
        t_val stored;
        stored     = t_val'(pay[VAL_KEEP-1:0]);
        res.status = ST_MISS;
        res.key    = key;
        res.value  = '0;
        hit        = -1;
        for (i = 0; i < table_count; i++)
            if (hit < 0 && table_keys[i] === key)
                hit = i;
        case (op)
            OP_INSERT: begin
                if (hit >= 0) begin
                    table_vals[hit] = stored;
                    res.status      = ST_UPDATED;
                    res.value       = OUT_VAL_W'(stored);
                end else if (table_count < CAPACITY) begin
                    table_keys[table_count] = key;
                    table_vals[table_count] = stored;
                    table_count++;
                    res.status = ST_NEW;
                    res.value  = OUT_VAL_W'(stored);
                end else begin
                    res.status = ST_FULL;
                end
            end
            OP_FIND: begin
                if (hit >= 0) begin
                    res.status = ST_FOUND;
                    res.value  = OUT_VAL_W'(table_vals[hit]);
                end
            end
            OP_ERASE: begin
                if (hit >= 0) begin
                    // close the gap: every later entry moves down one place
                    for (i = hit; i + 1 < table_count; i++) begin
                        table_keys[i] = table_keys[i + 1];
                        table_vals[i] = table_vals[i + 1];
                    end
                    table_count--;
                    res.status = ST_ERASED;
                end
            end
            default: begin
                table_count = 0;
                res.status  = ST_CLEARED;
            end
        endcase
        res.used = USED_W'(table_count);
    endtask

    always @(posedge i_clk) begin : watch
        t_table_result want;
        t_table_result fresh;
        if (!i_rst_n) begin
            table_count = 0;
            predicted_results.delete();
        end else begin
            // results first: a result never belongs to the operation accepted
            // at the same edge
            if (i_m_tvalid && i_m_tready) begin
                if (predicted_results.size() == 0) begin
                    report_mismatch("result with nothing pending, key_out",
                                    i_m_tdata[KEY_W-1:0], '0);
                end else begin
                    want = predicted_results.pop_front();
                    if (i_m_tuser !== want.status)
                        report_mismatch("status", 32'(i_m_tuser), 32'(want.status));
                    if (i_m_tdata[KEY_W-1:0] !== want.key)
                        report_mismatch("key_out", i_m_tdata[KEY_W-1:0], want.key);
                    if (i_m_tdata[KEY_W +: OUT_VAL_W] !== want.value)
                        report_mismatch("value_out", i_m_tdata[KEY_W +: OUT_VAL_W],
                                        want.value);
                    if (i_m_tdata[KEY_W+OUT_VAL_W +: USED_W] !== want.used)
                        report_mismatch("entries_used",
                                        32'(i_m_tdata[KEY_W+OUT_VAL_W +: USED_W]),
                                        32'(want.used));
                    if ((i_m_tdata >> M_FLD_W) !== '0)
                        report_mismatch("tdata padding", 32'(i_m_tdata >> M_FLD_W), '0);
                    o_status_seen[want.status] = 1'b1;
                    o_checked++;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                apply_table_op(t_op'(i_s_tuser), i_s_tdata[KEY_W-1:0],
                               i_s_tdata[KEY_W +: PAY_W], fresh);
                predicted_results.push_back(fresh);
                if (table_count > o_peak_used)
                    o_peak_used = table_count;
            end
        end
        o_pending = predicted_results.size();
    end

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the linear key-value table. A directed pass walks
// a miss on an empty table, the key and payload extremes, updates, a head
// erase with shifting, a full table with a refused insert, and a clear. A
// random pass then mixes fill-heavy and drain-heavy phases over a small key
// pool, with some free-form noise, random idling on both channels and long
// receiver hold-offs. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
    import lkvt_pkg::*;
();

    localparam int LIMIT_CYCLES = 600000;  // far above the slowest legal run
    localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
    localparam int DRAIN_CYCLES = 40;      // wait after the last result before the verdict
    localparam int RANDOM_ITEMS = 900;
    localparam int POOL_SIZE    = 18;

    localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
    localparam logic [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;   // [31:0] key, [63:32] payload
    logic [OP_W-1:0]     s_tuser  = OP_INSERT;  // [1:0] cmd
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;   // [31:0] key_out, [63:32] value_out, [68:64] entries_used
    logic [STATUS_W-1:0] m_tuser;   // [2:0] status

    int         fail_count;
    int         pending;
    int         checked;
    int         peak_used;
    logic [6:0] status_seen;

    int  cycle_count = 0;
    int  sent_count  = 0;
    int  hold_asks   = 0;   // written only by the stimulus process
    int  holds_done  = 0;   // written only by the receiver process
    bit  steady      = 1'b0;

    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    linear_key_value_table_top uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    kv_table_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_peak_used   (peak_used),
        .o_status_seen (status_seen)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Hard stop: count cycles and give up well past any legal run length.
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still pending", cycle_count, pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Idle length: mostly none, some short, a few long; none in a steady stretch.
    function automatic int pick_gap(input bit no_idle);
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one operation and hold it until the transfer. Called right after a
    // rising edge; valid is lowered only when a gap follows, so it never gets
    // two updates in one step.
    task automatic send_op(input t_op op, input logic [KEY_W-1:0] key,
                           input logic [PAY_W-1:0] pay);
        int gap;
        gap = pick_gap(steady);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {pay, key};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent_count++;
    endtask

    task automatic refresh_pool();
        int i;
        for (i = 0; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
    endtask

    // Receiver: random ready pattern, plus long hold-offs on request. Each
    // pass drives ready once and then waits on the clock.
    initial begin : sink
        int roll;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (holds_done < hold_asks) begin
                // hold off long enough for the block to fill up and stall its input
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 70) begin
                    m_tready <= 1'b1;
                    repeat ($urandom_range(1, 8)) @(posedge clk);
                end else if (roll < 94) begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                end else if (roll < 98) begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(10, 40)) @(posedge clk);
                end else begin
                    // stretch with no back-pressure at all
                    m_tready <= 1'b1;
                    repeat ($urandom_range(100, 200)) @(posedge clk);
                end
            end
        end
    end

    initial begin : stimulus
        int               n;
        int               i;
        int               roll;
        bit               filling;
        t_op              op;
        logic [KEY_W-1:0] key;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed pass ----
        send_op(OP_ERASE, 32'h1234_5678, $urandom);        // erase on an empty table
        send_op(OP_INSERT, KEY_MIN, 32'h0000_0000);
        send_op(OP_INSERT, KEY_MAX, 32'hFFFF_FFFF);
        send_op(OP_INSERT, 32'h0000_0000, 32'hA5A5_5A5A);
        send_op(OP_INSERT, 32'hFFFF_FFFF, 32'h5A5A_A5A5);
        send_op(OP_INSERT, KEY_MAX, 32'h0000_0001);        // overwrite an existing key
        send_op(OP_FIND, KEY_MIN, $urandom);               // payload must be ignored
        send_op(OP_FIND, 32'h0000_0001, $urandom);         // lookup miss
        send_op(OP_ERASE, KEY_MIN, $urandom);              // erase the head, shift all
        send_op(OP_FIND, 32'hFFFF_FFFF, $urandom);         // found after the shift
        for (i = 0; i < CAPACITY - 3; i++)
            send_op(OP_INSERT, 32'h0100_0000 + i, $urandom);
        send_op(OP_INSERT, 32'h0BAD_F00D, $urandom);       // new key into a full table
        send_op(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);  // update still allowed when full
        send_op(OP_ERASE, 32'h0100_0005, $urandom);        // erase from the middle
        send_op(OP_ERASE, 32'h0100_0000 + CAPACITY - 4, $urandom);  // erase the tail
        send_op(OP_CLEAR, $urandom, $urandom);

        // ---- random pass ----
        refresh_pool();
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            steady  = ((n / 100) % 3) == 2;
            filling = ((n / 75) % 2) == 0;
            if (n == 250 || n == 600)
                hold_asks++;
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                // noise: anything at all
                op  = t_op'($urandom_range(0, 3));
                key = $urandom;
            end else begin
                key  = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                roll = $urandom_range(0, 99);
                if (filling)
                    op = (roll < 65) ? OP_INSERT : (roll < 85) ? OP_FIND :
                         (roll < 98) ? OP_ERASE : OP_CLEAR;
                else
                    op = (roll < 25) ? OP_INSERT : (roll < 50) ? OP_FIND :
                         (roll < 98) ? OP_ERASE : OP_CLEAR;
            end
            send_op(op, key, $urandom);
            if (op == OP_CLEAR)
                refresh_pool();
        end
        s_tvalid <= 1'b0;

        // ---- drain and verdict ----
        // let the checker record the last transfer before reading its count
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d operations, checked %0d results; peak occupancy %0d of %0d.",
                 sent_count, checked, peak_used, CAPACITY);
        $display("Status codes seen (cleared..new): %07b; long receiver hold-offs: %0d.",
                 status_seen, holds_done);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: linear_key_value_table_top.f
+incdir+hw/rtl
hw/rtl/lkvt_pkg.sv
hw/rtl/lkvt_ctrl.sv
hw/rtl/lkvt_dp.sv
hw/rtl/linear_key_value_table_top.sv
sim/kv_table_checker.sv
sim/tb.sv
